// ===== sv/eulq_pkg.sv =====
package eulq_pkg;

   typedef struct packed {
      logic signed [15:0] yaw_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [15:0] quat_x;
      logic signed [15:0] quat_y;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } rsp_type;

   localparam int          TOL_WIDTH    = 20;
   localparam logic [19:0] TOL_RESET    = 20'd1074;
   localparam int          HALF_TURN    = 23040;
   localparam int          QUARTER_TURN = 11520;
   localparam int          FULL_TURN    = 46080;
   localparam longint      DEG2RAD_Q32  = 64'sd74961321;
   localparam longint      GAIN_Q30     = 64'sd652032874;
   localparam int          ATAN_ENTRIES = 24;

   // arc tangent of 2^-i in Q30
   function automatic longint atan_q30(input int i);
      longint v;
      case (i)
         0:       v = 843314856;
         1:       v = 497837829;
         2:       v = 263043836;
         3:       v = 133525158;
         4:       v = 67021686;
         5:       v = 33543515;
         6:       v = 16775850;
         7:       v = 8388437;
         8:       v = 4194282;
         9:       v = 2097149;
         10:      v = 1048575;
         11:      v = 524287;
         12:      v = 262143;
         13:      v = 131071;
         14:      v = 65535;
         15:      v = 32767;
         16:      v = 16383;
         17:      v = 8191;
         18:      v = 4095;
         19:      v = 2047;
         20:      v = 1023;
         21:      v = 511;
         22:      v = 255;
         23:      v = 127;
         default: v = 0;
      endcase
      return v;
   endfunction

   // round a nonnegative constant down by s bits, half up
   function automatic longint rnd_const(input longint v, input int s);
      longint r;
      if (s <= 0) begin
         r = v;
      end else begin
         r = (v + (64'sd1 <<< (s - 1))) >>> s;
      end
      return r;
   endfunction

endpackage

// ===== sv/euler_to_quaternion.sv =====
// channel | direction | handshake            | word
// req     | in        | req_valid/req_ready  | req_data  (yaw, pitch, roll)
// rsp     | out       | rsp_valid/rsp_ready  | rsp_data  (x, y, z, w)
// csr     | in        | csr_we               | csr_wdata (unit tolerance)
//
// One word enters per cycle while no result is held at rsp. CORDIC stages,
// a bit-per-stage square root and a bit-per-stage divider set the depth.
// Reset clears all valid bits and loads the tolerance with its default.
// A result held at rsp stalls every stage together; nothing moves or drops.
module euler_to_quaternion import eulq_pkg::*; #(
   parameter int CORDIC_STEPS = 16,
   parameter int FRAC_BITS    = 15
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [TOL_WIDTH-1:0] csr_wdata
);

   localparam int F   = FRAC_BITS;
   localparam int NS  = CORDIC_STEPS;
   localparam int W   = F + 3;           // CORDIC and product width
   localparam int PW  = 2 * W;
   localparam int QW  = W + 1;           // quaternion component width
   localparam int PQ  = 2 * QW;
   localparam int MW  = PQ + 2;          // squared magnitude width
   localparam int R   = MW / 2;          // root width
   localparam int RMW = MW + 2;
   localparam int NW  = QW + F + 1;      // dividend and quotient width
   localparam int E2  = 2 * F;
   localparam int E   = (E2 > 30) ? E2 : 30;
   localparam int CW  = MW + (E - E2) + 1;
   localparam int RS  = (F > 15) ? F - 15 : 0;
   localparam int LS  = (F < 15) ? 15 - F : 0;
   localparam int OW  = NW + 1 + LS + 1;
   localparam logic signed [W-1:0] GAIN_F = W'(rnd_const(GAIN_Q30, 30 - F));

   logic [TOL_WIDTH-1:0] tol_ff;
   logic                 adv;

   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_we) begin
         tol_ff <= csr_wdata;
      end
   end

   // wrap to one turn, fold into the first quadrant: {neg, flip, h}
   function automatic logic [15:0] reduce(input logic signed [15:0] a);
      logic signed [16:0] hv;
      logic               neg;
      logic               flip;
      hv = 17'(a);
      if (hv > 17'sd23040) hv = hv - 17'sd46080;
      if (hv <= -17'sd23040) hv = hv + 17'sd46080;
      neg = hv[16];
      if (neg) hv = -hv;
      flip = hv > 17'(QUARTER_TURN);
      if (flip) hv = 17'(HALF_TURN) - hv;
      return {neg, flip, hv[13:0]};
   endfunction

   function automatic logic signed [W-1:0] rmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
      logic signed [PW-1:0] p;
      p = PW'(a) * PW'(b);
      p = p + (PW'(1) <<< (F - 1));
      return W'(p >>> F);
   endfunction

   // ---------------- valid chain ----------------
   logic va_ff, vfx_ff, vp1_ff, vp2_ff, vq_ff, vsq_ff, rsp_valid_ff;
   logic vc_ff  [0:NS];
   logic vs_ff  [0:R];
   logic vdv_ff [0:NW];

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vfx_ff       <= 1'b0;
         vp1_ff       <= 1'b0;
         vp2_ff       <= 1'b0;
         vq_ff        <= 1'b0;
         vsq_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= NS; i++) vc_ff[i] <= 1'b0;
         for (int i = 0; i <= R; i++) vs_ff[i] <= 1'b0;
         for (int i = 0; i <= NW; i++) vdv_ff[i] <= 1'b0;
      end else if (adv) begin
         va_ff    <= req_valid;
         vc_ff[0] <= va_ff;
         for (int i = 1; i <= NS; i++) vc_ff[i] <= vc_ff[i-1];
         vfx_ff   <= vc_ff[NS];
         vp1_ff   <= vfx_ff;
         vp2_ff   <= vp1_ff;
         vq_ff    <= vp2_ff;
         vsq_ff   <= vq_ff;
         vs_ff[0] <= vsq_ff;
         for (int i = 1; i <= R; i++) vs_ff[i] <= vs_ff[i-1];
         vdv_ff[0] <= vs_ff[R];
         for (int i = 1; i <= NW; i++) vdv_ff[i] <= vdv_ff[i-1];
         rsp_valid_ff <= vdv_ff[NW];
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------- angle reduction ----------------
   logic [13:0] ha_ff   [0:2];
   logic        nega_ff [0:2];
   logic        flpa_ff [0:2];
   logic [15:0] red_in  [0:2];

   always_comb begin
      red_in[0] = reduce(req_data.yaw_angle);
      red_in[1] = reduce(req_data.pitch_angle);
      red_in[2] = reduce(req_data.roll_angle);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            ha_ff[a]   <= red_in[a][13:0];
            flpa_ff[a] <= red_in[a][14];
            nega_ff[a] <= red_in[a][15];
         end
      end
   end

   // ---------------- CORDIC ----------------
   logic signed [W-1:0] cx_ff  [0:NS][0:2];
   logic signed [W-1:0] cy_ff  [0:NS][0:2];
   logic signed [W-1:0] cz_ff  [0:NS][0:2];
   logic                cn_ff  [0:NS][0:2];
   logic                cf_ff  [0:NS][0:2];
   logic [40:0]         zp_in  [0:2];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         zp_in[a] = 41'(ha_ff[a]) * 41'(DEG2RAD_Q32);
         zp_in[a] = (zp_in[a] + (41'd1 << (38 - F))) >> (39 - F);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            cx_ff[0][a] <= GAIN_F;
            cy_ff[0][a] <= '0;
            cz_ff[0][a] <= W'(zp_in[a]);
            cn_ff[0][a] <= nega_ff[a];
            cf_ff[0][a] <= flpa_ff[a];
         end
      end
   end

   for (genvar i = 0; i < NS; i++) begin : g_cordic
      localparam logic signed [W-1:0] ANG = W'(rnd_const(atan_q30(i), 30 - F));
      always_ff @(posedge clock) begin
         if (adv) begin
            for (int a = 0; a < 3; a++) begin
               if (!cz_ff[i][a][W-1]) begin
                  cx_ff[i+1][a] <= cx_ff[i][a] - (cy_ff[i][a] >>> i);
                  cy_ff[i+1][a] <= cy_ff[i][a] + (cx_ff[i][a] >>> i);
                  cz_ff[i+1][a] <= cz_ff[i][a] - ANG;
               end else begin
                  cx_ff[i+1][a] <= cx_ff[i][a] + (cy_ff[i][a] >>> i);
                  cy_ff[i+1][a] <= cy_ff[i][a] - (cx_ff[i][a] >>> i);
                  cz_ff[i+1][a] <= cz_ff[i][a] + ANG;
               end
               cn_ff[i+1][a] <= cn_ff[i][a];
               cf_ff[i+1][a] <= cf_ff[i][a];
            end
         end
      end
   end

   // sine and cosine with quadrant fix-up: 0 yaw, 1 pitch, 2 roll
   logic signed [W-1:0] sn_ff [0:2];
   logic signed [W-1:0] cs_ff [0:2];

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int a = 0; a < 3; a++) begin
            sn_ff[a] <= cn_ff[NS][a] ? -cy_ff[NS][a] : cy_ff[NS][a];
            cs_ff[a] <= cf_ff[NS][a] ? -cx_ff[NS][a] : cx_ff[NS][a];
         end
      end
   end

   // ---------------- triple products ----------------
   logic signed [W-1:0] srcp_ff, crsp_ff, crcp_ff, srsp_ff;
   logic signed [W-1:0] sy1_ff, cy1_ff;
   logic signed [W-1:0] t_ff [0:7];

   always_ff @(posedge clock) begin
      if (adv) begin
         srcp_ff <= rmul(sn_ff[2], cs_ff[1]);
         crsp_ff <= rmul(cs_ff[2], sn_ff[1]);
         crcp_ff <= rmul(cs_ff[2], cs_ff[1]);
         srsp_ff <= rmul(sn_ff[2], sn_ff[1]);
         sy1_ff  <= sn_ff[0];
         cy1_ff  <= cs_ff[0];
         t_ff[0] <= rmul(srcp_ff, cy1_ff);
         t_ff[1] <= rmul(crsp_ff, sy1_ff);
         t_ff[2] <= rmul(crsp_ff, cy1_ff);
         t_ff[3] <= rmul(srcp_ff, sy1_ff);
         t_ff[4] <= rmul(crcp_ff, sy1_ff);
         t_ff[5] <= rmul(srsp_ff, cy1_ff);
         t_ff[6] <= rmul(crcp_ff, cy1_ff);
         t_ff[7] <= rmul(srsp_ff, sy1_ff);
      end
   end

   logic signed [QW-1:0] q_ff  [0:3];
   logic signed [QW-1:0] qs2_ff [0:3];
   logic [PQ-1:0]        sq_ff [0:3];

   always_ff @(posedge clock) begin
      if (adv) begin
         q_ff[0] <= QW'(t_ff[0]) - QW'(t_ff[1]);
         q_ff[1] <= QW'(t_ff[2]) + QW'(t_ff[3]);
         q_ff[2] <= QW'(t_ff[4]) - QW'(t_ff[5]);
         q_ff[3] <= QW'(t_ff[6]) + QW'(t_ff[7]);
         for (int k = 0; k < 4; k++) begin
            sq_ff[k]  <= PQ'(PQ'(q_ff[k]) * PQ'(q_ff[k]));
            qs2_ff[k] <= q_ff[k];
         end
      end
   end

   // ---------------- square root, one root bit per stage ----------------
   logic [RMW-1:0]       rem_ff  [0:R];
   logic [R-1:0]         root_ff [0:R];
   logic signed [QW-1:0] qr_ff   [0:R][0:3];
   logic                 nrm_ff  [1:R];
   logic [CW-1:0]        mag2e_in, one_in, tole_in, diff_in;
   logic                 nrm_in;

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0]  <= RMW'(sq_ff[0]) + RMW'(sq_ff[1]) + RMW'(sq_ff[2]) + RMW'(sq_ff[3]);
         root_ff[0] <= '0;
         for (int k = 0; k < 4; k++) qr_ff[0][k] <= qs2_ff[k];
      end
   end

   // skip normalization near zero and near one
   always_comb begin
      mag2e_in = CW'(rem_ff[0]) << (E - E2);
      one_in   = CW'(1) << E;
      tole_in  = CW'(tol_ff) << (E - 30);
      diff_in  = (mag2e_in > one_in) ? mag2e_in - one_in : one_in - mag2e_in;
      nrm_in   = (mag2e_in > tole_in) && (diff_in > tole_in);
   end

   for (genvar j = 0; j < R; j++) begin : g_sqrt
      localparam int B = R - 1 - j;
      logic [RMW-1:0] cand;
      assign cand = (RMW'(root_ff[j]) << (B + 1)) + (RMW'(1) << (2 * B));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (rem_ff[j] >= cand) begin
               rem_ff[j+1]  <= rem_ff[j] - cand;
               root_ff[j+1] <= root_ff[j] | (R'(1) << B);
            end else begin
               rem_ff[j+1]  <= rem_ff[j];
               root_ff[j+1] <= root_ff[j];
            end
            for (int k = 0; k < 4; k++) qr_ff[j+1][k] <= qr_ff[j][k];
         end
      end
      if (j == 0) begin : g_nrm_first
         always_ff @(posedge clock) begin
            if (adv) begin
               nrm_ff[1] <= nrm_in;
            end
         end
      end else begin : g_nrm_pass
         always_ff @(posedge clock) begin
            if (adv) begin
               nrm_ff[j+1] <= nrm_ff[j];
            end
         end
      end
   end

   // ---------------- division, one quotient bit per stage ----------------
   logic [R-1:0]         den_ff [0:NW];
   logic [NW-1:0]        num_ff [0:NW][0:3];
   logic [NW-1:0]        quo_ff [0:NW][0:3];
   logic [R-1:0]         drm_ff [0:NW][0:3];
   logic signed [QW-1:0] qd_ff  [0:NW][0:3];
   logic                 dn_ff  [0:NW];
   logic [QW-1:0]        mq_in  [0:3];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         mq_in[k] = qr_ff[R][k][QW-1] ? QW'(-qr_ff[R][k]) : QW'(qr_ff[R][k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         den_ff[0] <= root_ff[R];
         dn_ff[0]  <= nrm_ff[R] && (root_ff[R] != '0);
         for (int k = 0; k < 4; k++) begin
            num_ff[0][k] <= (NW'(mq_in[k]) << F) + NW'(root_ff[R] >> 1);
            quo_ff[0][k] <= '0;
            drm_ff[0][k] <= '0;
            qd_ff[0][k]  <= qr_ff[R][k];
         end
      end
   end

   for (genvar j = 0; j < NW; j++) begin : g_div
      logic [R:0] r2 [0:3];
      always_comb begin
         for (int k = 0; k < 4; k++) r2[k] = {drm_ff[j][k], num_ff[j][k][NW-1]};
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            den_ff[j+1] <= den_ff[j];
            dn_ff[j+1]  <= dn_ff[j];
            for (int k = 0; k < 4; k++) begin
               num_ff[j+1][k] <= num_ff[j][k] << 1;
               qd_ff[j+1][k]  <= qd_ff[j][k];
               if (r2[k] >= (R+1)'(den_ff[j])) begin
                  drm_ff[j+1][k] <= R'(r2[k] - (R+1)'(den_ff[j]));
                  quo_ff[j+1][k] <= {quo_ff[j][k][NW-2:0], 1'b1};
               end else begin
                  drm_ff[j+1][k] <= R'(r2[k]);
                  quo_ff[j+1][k] <= {quo_ff[j][k][NW-2:0], 1'b0};
               end
            end
         end
      end
   end

   // ---------------- Q1.15 rounding and saturation ----------------
   logic signed [OW-1:0] ov_in [0:3];
   logic signed [15:0]   oq_in [0:3];
   rsp_type              rsp_data_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (dn_ff[NW]) begin
            ov_in[k] = qd_ff[NW][k][QW-1] ? -OW'(quo_ff[NW][k]) : OW'(quo_ff[NW][k]);
         end else begin
            ov_in[k] = OW'(qd_ff[NW][k]);
         end
         ov_in[k] = ov_in[k] <<< LS;
         if (RS > 0) ov_in[k] = (ov_in[k] + (OW'(1) <<< (RS - 1))) >>> RS;
         if (ov_in[k] > OW'(32767)) begin
            oq_in[k] = 16'sh7fff;
         end else if (ov_in[k] < -OW'(32768)) begin
            oq_in[k] = -16'sh8000;
         end else begin
            oq_in[k] = 16'(ov_in[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff.quat_x <= oq_in[0];
         rsp_data_ff.quat_y <= oq_in[1];
         rsp_data_ff.quat_z <= oq_in[2];
         rsp_data_ff.quat_w <= oq_in[3];
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

// ===== sv/eulq_chk.sv =====
module eulq_chk import eulq_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a held result word stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   // the pipeline freezes only behind a stalled result
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("req taken while pipeline stalled");

   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("req blocked without a stall");

endmodule

bind euler_to_quaternion eulq_chk u_eulq_chk (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import eulq_pkg::*;

   localparam int CSTEPS  = 16;
   localparam int FBITS   = 15;
   localparam int LATENCY = 81;
   localparam int N_RAND  = 850;
   localparam longint CYCLE_LIMIT = 400000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   req_type              req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [TOL_WIDTH-1:0] csr_wdata = '0;

   logic [TOL_WIDTH-1:0] tol_model;
   rsp_type              quat_fifo[$];
   int                   n_fail = 0;
   longint               cycle_count = 0;

   typedef struct {
      req_type ang;
      bit      has_gold;
      rsp_type gold;
   } row_type;

   euler_to_quaternion #(.CORDIC_STEPS(CSTEPS), .FRAC_BITS(FBITS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint round_shr(longint v, int s);
      if (s <= 0) return v;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return round_shr(a * b, FBITS);
   endfunction

   function automatic longint int_sqrt(longint unsigned v);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(r);
   endfunction

   // half-angle sine/cosine; raw value is the half-angle in 2^-7 degree
   function automatic void half_sin_cos(input logic signed [15:0] raw,
                                        output longint s, output longint c);
      longint h, x, y, z, dx, dy, a;
      bit neg, flip;
      h = raw;
      if (h > HALF_TURN) h -= FULL_TURN;
      if (h <= -HALF_TURN) h += FULL_TURN;
      neg = h < 0;
      if (neg) h = -h;
      flip = h > QUARTER_TURN;
      if (flip) h = HALF_TURN - h;
      z = round_shr(h * DEG2RAD_Q32, 39 - FBITS);
      x = round_shr(GAIN_Q30, 30 - FBITS);
      y = 0;
      for (int i = 0; i < CSTEPS && i < ATAN_ENTRIES; i++) begin
         dx = floor_shr(y, i);
         dy = floor_shr(x, i);
         case (i)
            0: a = 843314856;  1: a = 497837829;  2: a = 263043836;
            3: a = 133525158;  4: a = 67021686;   5: a = 33543515;
            6: a = 16775850;   7: a = 8388437;    8: a = 4194282;
            9: a = 2097149;    10: a = 1048575;   11: a = 524287;
            12: a = 262143;    13: a = 131071;    14: a = 65535;
            15: a = 32767;     16: a = 16383;     17: a = 8191;
            18: a = 4095;      19: a = 2047;      20: a = 1023;
            21: a = 511;       22: a = 255;       default: a = 127;
         endcase
         a = round_shr(a, 30 - FBITS);
         if (z >= 0) begin
            x -= dx; y += dy; z -= a;
         end else begin
            x += dx; y -= dy; z += a;
         end
      end
      s = neg ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic logic signed [15:0] sat_q15(longint v);
      v = round_shr(v, FBITS - 15);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic rsp_type predict_quat(req_type ang);
      longint sy, cy, sp, cp, sr, cr, m, r, mag;
      longint q[4];
      longint unsigned mag2, one, diff;
      bit neg;
      rsp_type o;
      half_sin_cos(ang.yaw_angle, sy, cy);
      half_sin_cos(ang.pitch_angle, sp, cp);
      half_sin_cos(ang.roll_angle, sr, cr);
      q[0] = qmul(qmul(sr, cp), cy) - qmul(qmul(cr, sp), sy);
      q[1] = qmul(qmul(cr, sp), cy) + qmul(qmul(sr, cp), sy);
      q[2] = qmul(qmul(cr, cp), sy) - qmul(qmul(sr, sp), cy);
      q[3] = qmul(qmul(cr, cp), cy) + qmul(qmul(sr, sp), sy);
      mag2 = 0;
      for (int k = 0; k < 4; k++) mag2 += longint'(q[k] * q[k]);
      one = 64'd1 << 30;
      diff = mag2 > one ? mag2 - one : one - mag2;
      if (mag2 > tol_model && diff > tol_model) begin
         mag = int_sqrt(mag2);
         if (mag != 0) begin
            for (int k = 0; k < 4; k++) begin
               neg = q[k] < 0;
               m = neg ? -q[k] : q[k];
               r = ((m <<< FBITS) + mag / 2) / mag;
               q[k] = neg ? -r : r;
            end
         end
      end
      o.quat_x = sat_q15(q[0]);
      o.quat_y = sat_q15(q[1]);
      o.quat_z = sat_q15(q[2]);
      o.quat_w = sat_q15(q[3]);
      return o;
   endfunction

   // send one word, holding valid through accept
   task automatic send_angles(req_type ang, bit has_gold, rsp_type gold);
      req_valid <= 1'b1;
      req_data  <= ang;
      quat_fifo.push_back(has_gold ? gold : predict_quat(ang));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [TOL_WIDTH-1:0] v);
      req_valid <= 1'b0;
      while (quat_fifo.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      tol_model = v;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_angle();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 46080) - 23040;
         1: return 16'($urandom);
         2: return $urandom_range(0, 1) ? 16'sd23040 : -16'sd23040;
         default: return $urandom_range(0, 1280) - 640;
      endcase
   endfunction

   // receiver stall pattern: random runs of stall or flow, mostly flow
   initial begin
      int run;
      @(negedge reset);
      forever begin
         run = $urandom_range(0, 40);
         rsp_ready <= ($urandom_range(0, 3) != 0);
         repeat (run < 5 ? 1 : (run % 12) + 1) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (quat_fifo.size() == 0) begin
            $error("unexpected word quat=%h", rsp_data);
            n_fail++;
         end else begin
            rsp_type e;
            e = quat_fifo.pop_front();
            if (rsp_data.quat_x !== e.quat_x) begin
               $error("quat_x exp %0d got %0d", e.quat_x, rsp_data.quat_x); n_fail++;
            end
            if (rsp_data.quat_y !== e.quat_y) begin
               $error("quat_y exp %0d got %0d", e.quat_y, rsp_data.quat_y); n_fail++;
            end
            if (rsp_data.quat_z !== e.quat_z) begin
               $error("quat_z exp %0d got %0d", e.quat_z, rsp_data.quat_z); n_fail++;
            end
            if (rsp_data.quat_w !== e.quat_w) begin
               $error("quat_w exp %0d got %0d", e.quat_w, rsp_data.quat_w); n_fail++;
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      row_type rows[$];
      row_type rw;
      logic [TOL_WIDTH-1:0] tols[5];
      int burst;
      tol_model = TOL_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero, half turns, quadrant edges and wrap points, all via the predictor
      rows.push_back('{'{16'sd0, 16'sd0, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{16'sd23040, 16'sd0, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{-16'sd23040, 16'sd0, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{16'sd0, 16'sd23040, 16'sd0}, 1'b0, '0});
      rows.push_back('{'{16'sd0, 16'sd0, -16'sd23040}, 1'b0, '0});
      rows.push_back('{'{16'sd11520, 16'sd11520, 16'sd11520}, 1'b0, '0});
      rows.push_back('{'{-16'sd11520, 16'sd5760, -16'sd5760}, 1'b0, '0});
      rows.push_back('{'{16'sd32767, 16'sd32767, 16'sd32767}, 1'b0, '0});
      rows.push_back('{'{-16'sd32768, -16'sd32768, -16'sd32768}, 1'b0, '0});
      rows.push_back('{'{16'sd23041, -16'sd23039, 16'sd1}, 1'b0, '0});
      rows.push_back('{'{-16'sd1, 16'sd11521, 16'sd11519}, 1'b0, '0});
      rows.push_back('{'{16'sd5760, 16'sd17280, -16'sd17280}, 1'b0, '0});
      rows.push_back('{'{16'sd8000, -16'sd3000, 16'sd12345}, 1'b0, '0});
      foreach (rows[i]) send_angles(rows[i].ang, rows[i].has_gold, rows[i].gold);

      tols = '{20'd0, 20'hFFFFF, 20'd1, 20'd50000, TOL_RESET};
      for (int ph = 0; ph < 5; ph++) begin
         write_tolerance(tols[ph]);
         // the zero-tolerance phase repeats all directed rows
         if (ph == 0) foreach (rows[i]) send_angles(rows[i].ang, 1'b0, '0);
         for (int n = 0; n < N_RAND / 5; ) begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < N_RAND / 5; b++, n++) begin
               rw.ang.yaw_angle   = rand_angle();
               rw.ang.pitch_angle = rand_angle();
               rw.ang.roll_angle  = rand_angle();
               send_angles(rw.ang, 1'b0, '0);
            end
            if ($urandom_range(0, 2) != 0) idle_sender();
         end
      end
      req_valid <= 1'b0;

      while (quat_fifo.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (n_fail == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
